// ----- src/ybf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_pkg
// Shared widths, Q16 coefficients, register indexes and types for the
// YUYV to BGR converter with vertical flip.
// ----------------------------------------------------------------------------
package ybf_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int PPL_W      = 12;
    localparam int LPF_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int DELTA_W    = 9;
    localparam int FRAC_W     = 16;

    localparam int DEFAULT_MAX_PAIRS = 2048;
    localparam int DEFAULT_MAX_LINES = 4096;

    localparam logic [PPL_W-1:0] PPL_RESET = PPL_W'(320);
    localparam logic [LPF_W-1:0] LPF_RESET = LPF_W'(480);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_LINE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = CFG_IDX_W'(1);

    // BT.601 full range, Q16
    localparam logic signed [COEF_W-1:0] Q_RV = 18'sd91881;
    localparam logic signed [COEF_W-1:0] Q_GU = 18'sd22554;
    localparam logic signed [COEF_W-1:0] Q_GV = 18'sd46802;
    localparam logic signed [COEF_W-1:0] Q_BU = 18'sd116130;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } pos_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

endpackage
`default_nettype wire

// ----- src/ybf_chroma.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_chroma
// Shared chroma terms of a pair: Q16 products in stage 1, floored
// blue, green and red offsets in stage 2.
// ----------------------------------------------------------------------------
module ybf_chroma
(
    input  wire logic                                   clk,
    input  wire ybf_pkg::stage_en_t                     en,
    input  wire logic [ybf_pkg::PIX_W-1:0]              chroma_blue,
    input  wire logic [ybf_pkg::PIX_W-1:0]              chroma_red,
    output logic signed [ybf_pkg::DELTA_W-1:0]          d_blue,
    output logic signed [ybf_pkg::DELTA_W-1:0]          d_green,
    output logic signed [ybf_pkg::DELTA_W-1:0]          d_red
);

    localparam int GS_W = ybf_pkg::PROD_W + 1;

    logic signed [ybf_pkg::PIX_W-1:0]   du;
    logic signed [ybf_pkg::PIX_W-1:0]   dv;
    logic signed [ybf_pkg::PROD_W-1:0]  p_rv_reg;
    logic signed [ybf_pkg::PROD_W-1:0]  p_gu_reg;
    logic signed [ybf_pkg::PROD_W-1:0]  p_gv_reg;
    logic signed [ybf_pkg::PROD_W-1:0]  p_bu_reg;
    logic signed [GS_W-1:0]             g_sum;
    logic signed [ybf_pkg::PROD_W-1:0]  r_shift;
    logic signed [GS_W-1:0]             g_shift;
    logic signed [ybf_pkg::PROD_W-1:0]  b_shift;
    logic signed [ybf_pkg::DELTA_W-1:0] d_blue_reg;
    logic signed [ybf_pkg::DELTA_W-1:0] d_green_reg;
    logic signed [ybf_pkg::DELTA_W-1:0] d_red_reg;

    // sample minus 128 is the sample with its top bit flipped
    assign du = $signed({~chroma_blue[ybf_pkg::PIX_W-1], chroma_blue[ybf_pkg::PIX_W-2:0]});
    assign dv = $signed({~chroma_red[ybf_pkg::PIX_W-1], chroma_red[ybf_pkg::PIX_W-2:0]});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p_rv_reg <= dv * ybf_pkg::Q_RV;
            p_gu_reg <= du * ybf_pkg::Q_GU;
            p_gv_reg <= dv * ybf_pkg::Q_GV;
            p_bu_reg <= du * ybf_pkg::Q_BU;
        end
    end

    always_comb
    begin
        g_sum   = -GS_W'(p_gu_reg) - GS_W'(p_gv_reg);
        r_shift = p_rv_reg >>> ybf_pkg::FRAC_W;
        g_shift = g_sum >>> ybf_pkg::FRAC_W;
        b_shift = p_bu_reg >>> ybf_pkg::FRAC_W;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            d_red_reg   <= r_shift[ybf_pkg::DELTA_W-1:0];
            d_green_reg <= g_shift[ybf_pkg::DELTA_W-1:0];
            d_blue_reg  <= b_shift[ybf_pkg::DELTA_W-1:0];
        end
    end

    assign d_blue  = d_blue_reg;
    assign d_green = d_green_reg;
    assign d_red   = d_red_reg;

endmodule
`default_nettype wire

// ----- src/ybf_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_lane
// One pixel lane: adds the shared chroma offsets to its luma and clamps
// each channel to 0..255.
// ----------------------------------------------------------------------------
module ybf_lane
(
    input  wire logic        [ybf_pkg::PIX_W-1:0]   luma,
    input  wire logic signed [ybf_pkg::DELTA_W-1:0] d_blue,
    input  wire logic signed [ybf_pkg::DELTA_W-1:0] d_green,
    input  wire logic signed [ybf_pkg::DELTA_W-1:0] d_red,
    output logic             [ybf_pkg::PIX_W-1:0]   blue,
    output logic             [ybf_pkg::PIX_W-1:0]   green,
    output logic             [ybf_pkg::PIX_W-1:0]   red
);

    localparam int SUM_W = ybf_pkg::DELTA_W + 1;

    function automatic logic [ybf_pkg::PIX_W-1:0] add_clamp(
        input logic        [ybf_pkg::PIX_W-1:0]   y,
        input logic signed [ybf_pkg::DELTA_W-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        s = $signed(SUM_W'(y)) + SUM_W'(d);
        priority if (s < 0)
            add_clamp = '0;
        else if (s > $signed(SUM_W'(255)))
            add_clamp = '1;
        else
            add_clamp = s[ybf_pkg::PIX_W-1:0];
    endfunction

    assign blue  = add_clamp(luma, d_blue);
    assign green = add_clamp(luma, d_green);
    assign red   = add_clamp(luma, d_red);

endmodule
`default_nettype wire

// ----- src/ybf_pos.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_pos
// Geometry registers and pair/line counters; gives the flipped row, the
// pair column and the end-of-frame mark of each accepted item.
// ----------------------------------------------------------------------------
module ybf_pos
#(
    parameter int MAX_PAIRS = ybf_pkg::DEFAULT_MAX_PAIRS,
    parameter int MAX_LINES = ybf_pkg::DEFAULT_MAX_LINES
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [ybf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ybf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              accept,
    output ybf_pkg::pos_t                          pos
);

    localparam int PW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int LW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int PBW = $clog2(MAX_PAIRS + 1);
    localparam int LBW = $clog2(MAX_LINES + 1);
    localparam int PCW = (PBW > ybf_pkg::PPL_W) ? PBW : ybf_pkg::PPL_W;
    localparam int LCW = (LBW > ybf_pkg::LPF_W) ? LBW : ybf_pkg::LPF_W;

    logic [ybf_pkg::PPL_W-1:0] ppl_reg;
    logic [ybf_pkg::LPF_W-1:0] lpf_reg;
    logic [PW-1:0]             pc_reg;
    logic [PW-1:0]             pc_next;
    logic [LW-1:0]             lc_reg;
    logic [LW-1:0]             lc_next;
    logic [PCW-1:0]            pairs_b;
    logic [LCW-1:0]            lines_b;
    logic [PCW-1:0]            pc_eff;
    logic [LCW-1:0]            lc_eff;
    logic [LCW-1:0]            row_full;
    logic                      pc_last;
    logic                      lc_last;

    always_comb
    begin
        priority if (ppl_reg == '0)
            pairs_b = PCW'(1);
        else if (PCW'(ppl_reg) > PCW'(MAX_PAIRS))
            pairs_b = PCW'(MAX_PAIRS);
        else
            pairs_b = PCW'(ppl_reg);

        priority if (lpf_reg == '0)
            lines_b = LCW'(1);
        else if (LCW'(lpf_reg) > LCW'(MAX_LINES))
            lines_b = LCW'(MAX_LINES);
        else
            lines_b = LCW'(lpf_reg);

        // a counter left past a shrunken bound restarts at zero
        pc_eff   = (PCW'(pc_reg) >= pairs_b) ? '0 : PCW'(pc_reg);
        lc_eff   = (LCW'(lc_reg) >= lines_b) ? '0 : LCW'(lc_reg);
        pc_last  = (pc_eff == pairs_b - PCW'(1));
        lc_last  = (lc_eff == lines_b - LCW'(1));
        row_full = lines_b - LCW'(1) - lc_eff;

        pc_next = pc_reg;
        lc_next = lc_reg;
        if (accept)
        begin
            if (pc_last)
            begin
                pc_next = '0;
                lc_next = lc_last ? '0 : LW'(lc_eff + LCW'(1));
            end
            else
            begin
                pc_next = PW'(pc_eff + PCW'(1));
                lc_next = LW'(lc_eff);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppl_reg <= ybf_pkg::PPL_RESET;
            lpf_reg <= ybf_pkg::LPF_RESET;
            pc_reg  <= '0;
            lc_reg  <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            lc_reg <= lc_next;
            if (cfg_write)
            begin
                priority if (cfg_index == ybf_pkg::CFG_PAIRS_PER_LINE)
                    ppl_reg <= cfg_data[ybf_pkg::PPL_W-1:0];
                else if (cfg_index == ybf_pkg::CFG_LINES_PER_FRAME)
                    lpf_reg <= cfg_data[ybf_pkg::LPF_W-1:0];
                else
                    ppl_reg <= ppl_reg;
            end
        end
    end

    assign pos.row  = row_full[ybf_pkg::ROW_W-1:0];
    assign pos.col  = pc_eff[ybf_pkg::COL_W-1:0];
    assign pos.last = pc_last && lc_last;

    a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos.last |=> (pc_reg == '0) && (lc_reg == '0))
        else $error("counters did not wrap after the last pair");

endmodule
`default_nettype wire

// ----- src/yuyv_to_bgr_flip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuyv_to_bgr_flip
// YUYV 4:2:2 macropixel to two BGR 8:8:8 pixels, BT.601 full range, with
// the pair placed in a vertically flipped frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one macropixel per item: Y0, U,
//   Y1, V. Output channel (out_valid/out_ready) gives two BGR pixels sharing
//   the chroma, the flipped row, the pair column and an end-of-frame mark.
//   Config channel (cfg_valid/cfg_ready, always ready) writes pairs_per_line
//   (index 0) and lines_per_frame (index 1); write only while idle.
//   The three pipeline stages are products, floored chroma offsets, then the
//   two pixel lanes into the output register. Throughput is one item per
//   cycle while out_ready stays high; a stage advances only when not held.
//   When the receiver stalls, the output register holds its item and the
//   stages behind it keep filling until every stage is full; in_ready then
//   drops. Reset empties the pipeline, zeroes the counters and loads the
//   geometry with 320 pairs by 480 lines.
// ----------------------------------------------------------------------------
module yuyv_to_bgr_flip
#(
    parameter int MAX_PAIRS = ybf_pkg::DEFAULT_MAX_PAIRS,
    parameter int MAX_LINES = ybf_pkg::DEFAULT_MAX_LINES
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ybf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ybf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ybf_pkg::PIX_W-1:0]       luma_first,
    input  wire logic [ybf_pkg::PIX_W-1:0]       chroma_blue,
    input  wire logic [ybf_pkg::PIX_W-1:0]       luma_second,
    input  wire logic [ybf_pkg::PIX_W-1:0]       chroma_red,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [ybf_pkg::PIX_W-1:0]            blue_first,
    output logic [ybf_pkg::PIX_W-1:0]            green_first,
    output logic [ybf_pkg::PIX_W-1:0]            red_first,
    output logic [ybf_pkg::PIX_W-1:0]            blue_second,
    output logic [ybf_pkg::PIX_W-1:0]            green_second,
    output logic [ybf_pkg::PIX_W-1:0]            red_second,
    output logic [ybf_pkg::ROW_W-1:0]            dest_row,
    output logic [ybf_pkg::COL_W-1:0]            dest_pair_col,
    output logic                                 frame_end
);

    logic                                   accept;
    logic                                   en3;
    ybf_pkg::stage_en_t                     en;
    ybf_pkg::pos_t                          pos;
    logic                                   v1_reg;
    logic                                   v2_reg;
    logic                                   v3_reg;
    logic [ybf_pkg::PIX_W-1:0]              y0_s1_reg;
    logic [ybf_pkg::PIX_W-1:0]              y1_s1_reg;
    logic [ybf_pkg::PIX_W-1:0]              y0_s2_reg;
    logic [ybf_pkg::PIX_W-1:0]              y1_s2_reg;
    ybf_pkg::pos_t                          pos_s1_reg;
    ybf_pkg::pos_t                          pos_s2_reg;
    logic signed [ybf_pkg::DELTA_W-1:0]     d_blue;
    logic signed [ybf_pkg::DELTA_W-1:0]     d_green;
    logic signed [ybf_pkg::DELTA_W-1:0]     d_red;
    logic [ybf_pkg::PIX_W-1:0]              b0;
    logic [ybf_pkg::PIX_W-1:0]              g0;
    logic [ybf_pkg::PIX_W-1:0]              r0;
    logic [ybf_pkg::PIX_W-1:0]              b1;
    logic [ybf_pkg::PIX_W-1:0]              g1;
    logic [ybf_pkg::PIX_W-1:0]              r1;
    logic [ybf_pkg::PIX_W-1:0]              b0_reg;
    logic [ybf_pkg::PIX_W-1:0]              g0_reg;
    logic [ybf_pkg::PIX_W-1:0]              r0_reg;
    logic [ybf_pkg::PIX_W-1:0]              b1_reg;
    logic [ybf_pkg::PIX_W-1:0]              g1_reg;
    logic [ybf_pkg::PIX_W-1:0]              r1_reg;
    ybf_pkg::pos_t                          pos_out_reg;

    // a stage moves when it is empty or the one after it moves
    assign en3      = !v3_reg || out_ready;
    assign en.s2    = !v2_reg || en3;
    assign en.s1    = !v1_reg || en.s2;
    assign in_ready = en.s1;
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    ybf_pos #(
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_LINES (MAX_LINES)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos)
    );

    ybf_chroma u_chroma (
        .clk         (clk),
        .en          (en),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .d_blue      (d_blue),
        .d_green     (d_green),
        .d_red       (d_red)
    );

    ybf_lane u_lane_first (
        .luma    (y0_s2_reg),
        .d_blue  (d_blue),
        .d_green (d_green),
        .d_red   (d_red),
        .blue    (b0),
        .green   (g0),
        .red     (r0)
    );

    ybf_lane u_lane_second (
        .luma    (y1_s2_reg),
        .d_blue  (d_blue),
        .d_green (d_green),
        .d_red   (d_red),
        .blue    (b1),
        .green   (g1),
        .red     (r1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= in_valid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            y0_s1_reg  <= luma_first;
            y1_s1_reg  <= luma_second;
            pos_s1_reg <= pos;
        end
        if (en.s2)
        begin
            y0_s2_reg  <= y0_s1_reg;
            y1_s2_reg  <= y1_s1_reg;
            pos_s2_reg <= pos_s1_reg;
        end
        if (en3)
        begin
            b0_reg      <= b0;
            g0_reg      <= g0;
            r0_reg      <= r0;
            b1_reg      <= b1;
            g1_reg      <= g1;
            r1_reg      <= r1;
            pos_out_reg <= pos_s2_reg;
        end
    end

    assign out_valid     = v3_reg;
    assign blue_first    = b0_reg;
    assign green_first   = g0_reg;
    assign red_first     = r0_reg;
    assign blue_second   = b1_reg;
    assign green_second  = g1_reg;
    assign red_second    = r1_reg;
    assign dest_row      = pos_out_reg.row;
    assign dest_pair_col = pos_out_reg.col;
    assign frame_end     = pos_out_reg.last;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted item missing from stage 1");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en.s2 |=> v2_reg)
        else $error("stalled stage 2 item lost");

    a_frame_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> dest_row == '0)
        else $error("end of frame not on flipped row zero");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the YUYV to BGR converter with vertical flip.
// Macropixels go in over a valid/ready channel with random gaps. A class keeps
// its own copy of the geometry and pair/line counters and predicts both
// pixels and the flipped position. Each output item is compared field by field
// with the oldest prediction. The frame geometry is rewritten between phases,
// with small frames so that lines and frames wrap, out-of-range values and
// the largest sizes. The receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import ybf_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int LIMIT_CYCLES = 400000;
    localparam int CORNER_COUNT = 20;
    localparam int GEOM_COUNT   = 9;

    // Y0 U Y1 V
    localparam logic [31:0] CORNER_PIXELS [CORNER_COUNT] = '{
        32'h00_00_00_00, 32'hFF_FF_FF_FF, 32'h00_80_FF_80, 32'hFF_80_00_80,
        32'hFF_00_00_FF, 32'h00_FF_FF_00, 32'hFF_00_FF_00, 32'h00_FF_00_FF,
        32'h80_80_80_80, 32'h64_7F_64_81, 32'h64_81_64_7F, 32'h00_7F_00_7F,
        32'hFF_81_FF_81, 32'h01_7F_FE_81, 32'h10_00_EB_FF, 32'hEB_FF_10_00,
        32'h55_AA_AA_55, 32'hAA_55_55_AA, 32'h80_01_80_FE, 32'h7F_FE_80_01
    };

    localparam logic [CFG_DATA_W-1:0] GEOM_PAIRS [GEOM_COUNT] = '{
        13'd1, 13'd0, 13'd3, 13'h1FFF, 13'd2048, 13'd1, 13'h1000, 13'd2049, 13'd5
    };
    localparam logic [CFG_DATA_W-1:0] GEOM_LINES [GEOM_COUNT] = '{
        13'd1, 13'd0, 13'd2, 13'h1FFF, 13'd4096, 13'd4096, 13'd4097, 13'd3, 13'd2
    };

    typedef struct packed {
        logic [PIX_W-1:0] y0;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] y1;
        logic [PIX_W-1:0] v;
    } macropixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] b0;
        logic [PIX_W-1:0] g0;
        logic [PIX_W-1:0] r0;
        logic [PIX_W-1:0] b1;
        logic [PIX_W-1:0] g1;
        logic [PIX_W-1:0] r1;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } bgr_pair_t;

    class bgr_pair_checker;
        bgr_pair_t        expected_pairs[$];
        logic [PPL_W-1:0] pairs_reg;
        logic [LPF_W-1:0] lines_reg;
        int               pair_cnt;
        int               line_cnt;
        int               errors;
        int               result_count;

        function new();
            pairs_reg    = PPL_RESET;
            lines_reg    = LPF_RESET;
            pair_cnt     = 0;
            line_cnt     = 0;
            errors       = 0;
            result_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PAIRS_PER_LINE)
                pairs_reg = data[PPL_W-1:0];
            else if (idx == CFG_LINES_PER_FRAME)
                lines_reg = data[LPF_W-1:0];
        endfunction

        function int effective_bound(int v, int maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function logic [PIX_W-1:0] clamp_channel(int x);
            if (x < 0)
                return '0;
            if (x > 255)
                return 8'hFF;
            return x[PIX_W-1:0];
        endfunction

        function void note_macropixel(macropixel_t px);
            int du;
            int dv;
            int rd;
            int gd;
            int bd;
            int pairs;
            int lines;
            bgr_pair_t e;
            du = int'(px.u) - 128;
            dv = int'(px.v) - 128;
            // arithmetic shift of a signed int floors
            rd = (int'(Q_RV) * dv) >>> FRAC_W;
            gd = (-(int'(Q_GU) * du) - int'(Q_GV) * dv) >>> FRAC_W;
            bd = (int'(Q_BU) * du) >>> FRAC_W;
            pairs = effective_bound(int'(pairs_reg), DEFAULT_MAX_PAIRS);
            lines = effective_bound(int'(lines_reg), DEFAULT_MAX_LINES);
            if (pair_cnt >= pairs)
                pair_cnt = 0;
            if (line_cnt >= lines)
                line_cnt = 0;
            e.b0   = clamp_channel(int'(px.y0) + bd);
            e.g0   = clamp_channel(int'(px.y0) + gd);
            e.r0   = clamp_channel(int'(px.y0) + rd);
            e.b1   = clamp_channel(int'(px.y1) + bd);
            e.g1   = clamp_channel(int'(px.y1) + gd);
            e.r1   = clamp_channel(int'(px.y1) + rd);
            e.row  = ROW_W'(lines - 1 - line_cnt);
            e.col  = COL_W'(pair_cnt);
            e.last = (pair_cnt == pairs - 1) && (line_cnt == lines - 1);
            expected_pairs.push_back(e);
            if (pair_cnt + 1 >= pairs) begin
                pair_cnt = 0;
                line_cnt = (line_cnt + 1 >= lines) ? 0 : line_cnt + 1;
            end
            else begin
                pair_cnt++;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, int got, int exp);
            if (got != exp)
                report_mismatch($sformatf("item %0d %s got %0d exp %0d",
                                          result_count, name, got, exp));
        endtask

        task check_result(bgr_pair_t got);
            bgr_pair_t e;
            if (expected_pairs.size() == 0) begin
                report_mismatch("output item with no input pending");
                return;
            end
            e = expected_pairs.pop_front();
            check_field("blue_first", got.b0, e.b0);
            check_field("green_first", got.g0, e.g0);
            check_field("red_first", got.r0, e.r0);
            check_field("blue_second", got.b1, e.b1);
            check_field("green_second", got.g1, e.g1);
            check_field("red_second", got.r1, e.r1);
            check_field("dest_row", got.row, e.row);
            check_field("dest_pair_col", got.col, e.col);
            check_field("frame_end", got.last, e.last);
            result_count++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      luma_first    = '0;
    logic [PIX_W-1:0]      chroma_blue   = '0;
    logic [PIX_W-1:0]      luma_second   = '0;
    logic [PIX_W-1:0]      chroma_red    = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [PIX_W-1:0]      blue_first;
    logic [PIX_W-1:0]      green_first;
    logic [PIX_W-1:0]      red_first;
    logic [PIX_W-1:0]      blue_second;
    logic [PIX_W-1:0]      green_second;
    logic [PIX_W-1:0]      red_second;
    logic [ROW_W-1:0]      dest_row;
    logic [COL_W-1:0]      dest_pair_col;
    logic                  frame_end;

    bgr_pair_checker sb;
    int unsigned     cycle_count = 0;
    int              ready_mode  = 0;
    int              stall_left  = 0;

    yuyv_to_bgr_flip u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .luma_first    (luma_first),
        .chroma_blue   (chroma_blue),
        .luma_second   (luma_second),
        .chroma_red    (chroma_red),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blue_first    (blue_first),
        .green_first   (green_first),
        .red_first     (red_first),
        .blue_second   (blue_second),
        .green_second  (green_second),
        .red_second    (red_second),
        .dest_row      (dest_row),
        .dest_pair_col (dest_pair_col),
        .frame_end     (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[yuyv_to_bgr_flip] ERROR");
            $finish;
        end
    end

    // receiver: short stalls mostly, a few long ones; mode 0 starts no new stall
    always @(posedge clk)
    begin : ready_gen
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (ready_mode == 0 || r < 70) begin
            out_ready <= 1'b1;
        end
        else begin
            out_ready  <= 1'b0;
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
    end

    always @(posedge clk)
    begin : monitor
        bgr_pair_t seen;
        if (rst_n && out_valid && out_ready) begin
            seen.b0   = blue_first;
            seen.g0   = green_first;
            seen.r0   = red_first;
            seen.b1   = blue_second;
            seen.g1   = green_second;
            seen.r1   = red_second;
            seen.row  = dest_row;
            seen.col  = dest_pair_col;
            seen.last = frame_end;
            sb.check_result(seen);
        end
    end

    task automatic wait_drained();
        while (sb.expected_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_geometry(bit do_pairs, logic [CFG_DATA_W-1:0] pairs_val,
                                bit do_lines, logic [CFG_DATA_W-1:0] lines_val);
        wait_drained();
        repeat (4) @(posedge clk);
        if (do_pairs)
            push_reg(CFG_PAIRS_PER_LINE, pairs_val);
        if (do_lines)
            push_reg(CFG_LINES_PER_FRAME, lines_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(macropixel_t px);
        in_valid    <= 1'b1;
        luma_first  <= px.y0;
        chroma_blue <= px.u;
        luma_second <= px.y1;
        chroma_red  <= px.v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_macropixel(px);
    endtask

    function automatic logic [PIX_W-1:0] pick_sample();
        logic [PIX_W-1:0] edge_vals [5];
        edge_vals = '{8'h00, 8'h7F, 8'h80, 8'h81, 8'hFF};
        if ($urandom_range(0, 9) == 0)
            return edge_vals[$urandom_range(0, 4)];
        return PIX_W'($urandom);
    endfunction

    // valid stays high across back-to-back items; it drops for a gap, a drain hold or the end
    task automatic run_items(int count, bit corners, bit burst, int hold_at);
        macropixel_t px;
        int gap;
        int r;
        for (int i = 0; i < count; i++) begin
            r   = $urandom_range(0, 99);
            gap = (burst || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 40);
            if (i == hold_at) begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait_drained();
            end
            else if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if (corners) begin
                px = CORNER_PIXELS[i];
            end
            else begin
                px.y0 = pick_sample();
                px.u  = pick_sample();
                px.y1 = pick_sample();
                px.v  = pick_sample();
            end
            send_pixel(px);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          sent;
        int          phase;
        int          count;
        int          hold_at;
        int          r;
        logic [1:0]  which;
        logic [CFG_DATA_W-1:0] pv;
        logic [CFG_DATA_W-1:0] lv;
        sb = new();
        sent  = 0;
        phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        ready_mode = 1;
        run_items(CORNER_COUNT, 1'b1, 1'b0, -1);

        while (sent < RANDOM_ITEMS) begin
            if (phase < GEOM_COUNT) begin
                set_geometry(1'b1, GEOM_PAIRS[phase], 1'b1, GEOM_LINES[phase]);
            end
            else begin
                which = 2'($urandom_range(1, 3));
                r  = $urandom_range(0, 99);
                pv = (r < 10) ? '0 : (r < 75) ? CFG_DATA_W'($urandom_range(1, 9))
                                              : CFG_DATA_W'($urandom);
                r  = $urandom_range(0, 99);
                lv = (r < 10) ? '0 : (r < 75) ? CFG_DATA_W'($urandom_range(1, 6))
                                              : CFG_DATA_W'($urandom);
                set_geometry(which[0], pv, which[1], lv);
            end
            ready_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            count      = $urandom_range(15, 90);
            hold_at    = (phase == 2 || $urandom_range(0, 7) == 0)
                         ? $urandom_range(1, count - 1) : -1;
            run_items(count, 1'b0, $urandom_range(0, 3) == 0, hold_at);
            sent += count;
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_pairs.size() == 0)
            $display("[yuyv_to_bgr_flip] OK");
        else
            $display("[yuyv_to_bgr_flip] ERROR");
        $finish;
    end

endmodule
